[src/bmb_pkg.sv]
// ----------------------------------------------------------------------------
// Band meter package
// Shared widths, constants and the item type that moves from the front end
// through the queue to the back end of the band meter.
// ----------------------------------------------------------------------------
package bmb_pkg;

    // Field widths fixed by the interface.
    localparam int BAND_W  = 5;
    localparam int MAG_W   = 8;
    localparam int LEVEL_W = 8;
    localparam int SMOOTH_W = 16;   // unsigned 8.8 fixed point

    // Number of bands held in state. It cannot exceed what the band field
    // can address.
    localparam int NUM_BANDS  = 32;
    localparam int BAND_IDX_W = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;

    // Ballistics, in 1/256 steps.
    localparam logic [7:0] ATTACK_COEF = 8'd141;
    localparam logic [7:0] DECAY_COEF  = 8'd56;
    localparam logic [7:0] ROUND_HALF  = 8'd128;

    // Peak cap fall per update and output ceiling.
    localparam logic [LEVEL_W-1:0] CAP_FALL  = 8'd3;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;

    // Reset gain in percent.
    localparam logic [7:0] SENS_RESET = 8'd100;

    // Division by 100 of a 16-bit product: x / 100 == (x * 83887) >> 23,
    // exact for every x below 65536.
    localparam int DIV100_MUL_W = 17;
    localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 17'd83887;
    localparam int DIV100_SHIFT = 23;
    localparam int GAIN_PROD_W  = LEVEL_W + 8;
    localparam int DIV_PROD_W   = GAIN_PROD_W + DIV100_MUL_W;

    // Queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One classified beat.
    typedef struct packed {
        logic [BAND_W-1:0] band;
        logic [MAG_W-1:0]  mag;
        logic              in_range;
    } t_item;

endpackage

[src/bmb_front.sv]
// ----------------------------------------------------------------------------
// Band meter front end
// Accepts input beats, checks the band against the state depth and holds the
// classified beat until the queue takes it.
// ----------------------------------------------------------------------------
module bmb_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [bmb_pkg::BAND_W-1:0] i_band_index,
    input  logic [bmb_pkg::MAG_W-1:0]  i_band_magnitude,
    input  logic                     i_q_full,
    output logic                     o_push,
    output bmb_pkg::t_item           o_item
);
    import bmb_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  accept;

    // The held beat leaves whenever the queue has room.
    assign o_push     = r_valid && !i_q_full;
    assign o_in_stall = r_valid && i_q_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.band     <= i_band_index;
            r_item.mag      <= i_band_magnitude;
            r_item.in_range <= (32'(i_band_index) < NUM_BANDS);
        end
    end

endmodule

[src/bmb_queue.sv]
// ----------------------------------------------------------------------------
// Band meter queue
// Small register FIFO that decouples the front end from the back pipeline.
// ----------------------------------------------------------------------------
module bmb_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bmb_pkg::t_item i_push_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output bmb_pkg::t_item o_item
);
    import bmb_pkg::*;

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        if (i_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

[src/bmb_back.sv]
// ----------------------------------------------------------------------------
// Band meter back end
// Four-stage pipeline: smoothing with per-band state, gain multiply,
// division by 100, then saturation, peak cap update and the output register.
// ----------------------------------------------------------------------------
module bmb_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [7:0]                  i_cfg_wr_data,
    input  logic                        i_q_valid,
    input  bmb_pkg::t_item              i_q_item,
    output logic                        o_pop,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [bmb_pkg::BAND_W-1:0]  o_out_band,
    output logic [bmb_pkg::LEVEL_W-1:0] o_shown_level,
    output logic [bmb_pkg::LEVEL_W-1:0] o_peak_cap
);
    import bmb_pkg::*;

    // Per-band state.
    logic [SMOOTH_W-1:0] r_level [NUM_BANDS];
    logic [LEVEL_W-1:0]  r_cap   [NUM_BANDS];
    logic [7:0]          r_sens;

    // Whole pipeline moves together when the output register is free.
    logic adv;

    // Stage A: smoothing.
    logic [BAND_IDX_W-1:0] a_idx;
    logic [SMOOTH_W-1:0]   a_cur;
    logic [SMOOTH_W-1:0]   a_target;
    logic                  a_rising;
    logic [SMOOTH_W-1:0]   a_diff;
    logic [7:0]            a_coef;
    logic [SMOOTH_W+8:0]   a_scaled;
    logic [SMOOTH_W-1:0]   a_step;
    logic [SMOOTH_W-1:0]   n_level;

    logic                  r_a_valid;
    logic [BAND_W-1:0]     r_a_band;
    logic                  r_a_ok;
    logic [SMOOTH_W-1:0]   r_a_level;

    // Stage B: rounding and gain.
    logic [SMOOTH_W:0]     b_round;
    logic [LEVEL_W-1:0]    b_lvl;
    logic                  r_b_valid;
    logic [BAND_W-1:0]     r_b_band;
    logic                  r_b_ok;
    logic [GAIN_PROD_W-1:0] r_b_prod;

    // Stage C: reciprocal multiply for the division by 100.
    logic                  r_c_valid;
    logic [BAND_W-1:0]     r_c_band;
    logic                  r_c_ok;
    logic [DIV_PROD_W-1:0] r_c_prod;

    // Stage D: saturation and peak cap.
    logic [BAND_IDX_W-1:0]            d_idx;
    logic [DIV_PROD_W-DIV100_SHIFT-1:0] d_quot;
    logic [LEVEL_W-1:0]               d_shown;
    logic [LEVEL_W-1:0]               d_old_cap;
    logic [LEVEL_W-1:0]               n_cap;

    assign adv   = !o_out_valid || !i_out_stall;
    assign o_pop = adv && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sens <= SENS_RESET;
        end else if (i_cfg_wr_en) begin
            r_sens <= i_cfg_wr_data;
        end
    end

    // The level moves toward the magnitude by a rounded fraction of the gap,
    // fast on the way up and slow on the way down. The step never exceeds
    // the gap, so it fits the state width.
    always_comb begin
        a_idx    = i_q_item.band[BAND_IDX_W-1:0];
        a_cur    = r_level[a_idx];
        a_target = {i_q_item.mag, 8'h00};
        a_rising = (a_target > a_cur);
        a_diff   = a_rising ? (a_target - a_cur) : (a_cur - a_target);
        a_coef   = a_rising ? ATTACK_COEF : DECAY_COEF;
        a_scaled = (SMOOTH_W+9)'(a_diff * a_coef) + (SMOOTH_W+9)'(ROUND_HALF);
        a_step   = a_scaled[SMOOTH_W+7:8];
        n_level  = a_rising ? (a_cur + a_step) : (a_cur - a_step);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_BANDS; i++) begin
                r_level[i] <= '0;
            end
        end else if (o_pop && i_q_item.in_range) begin
            r_level[a_idx] <= n_level;
        end
    end

    always_comb begin
        b_round = {1'b0, r_a_level} + (SMOOTH_W+1)'(ROUND_HALF);
        b_lvl   = (b_round[SMOOTH_W:8] > {1'b0, LEVEL_MAX}) ? LEVEL_MAX
                                                             : b_round[15:8];
    end

    always_comb begin
        d_idx     = r_c_band[BAND_IDX_W-1:0];
        d_quot    = r_c_prod[DIV_PROD_W-1:DIV100_SHIFT];
        d_shown   = (d_quot > (DIV_PROD_W-DIV100_SHIFT)'(LEVEL_MAX)) ? LEVEL_MAX
                                                                     : d_quot[7:0];
        d_old_cap = r_cap[d_idx];
        if (d_shown > d_old_cap) begin
            n_cap = d_shown;
        end else if (d_old_cap >= CAP_FALL) begin
            n_cap = d_old_cap - CAP_FALL;
        end else begin
            n_cap = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_BANDS; i++) begin
                r_cap[i] <= '0;
            end
        end else if (adv && r_c_valid && r_c_ok) begin
            r_cap[d_idx] <= n_cap;
        end
    end

    // Valid bits of the stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            o_out_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid   <= i_q_valid;
            r_b_valid   <= r_a_valid;
            r_c_valid   <= r_b_valid;
            o_out_valid <= r_c_valid;
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_band  <= i_q_item.band;
            r_a_ok    <= i_q_item.in_range;
            r_a_level <= n_level;

            r_b_band  <= r_a_band;
            r_b_ok    <= r_a_ok;
            r_b_prod  <= GAIN_PROD_W'(b_lvl * r_sens);

            r_c_band  <= r_b_band;
            r_c_ok    <= r_b_ok;
            r_c_prod  <= DIV_PROD_W'(r_b_prod * DIV100_MUL);

            o_out_band    <= r_c_band;
            o_shown_level <= r_c_ok ? d_shown : '0;
            o_peak_cap    <= r_c_ok ? n_cap : '0;
        end
    end

endmodule

[src/band_meter_ballistics_peak_hold.sv]
// ----------------------------------------------------------------------------
// Band meter with attack/decay ballistics and peak hold
// Path: front-end register, queue, back stages A, B and C, output register.
// Throughput: one beat per cycle, sustained, for any mix of bands, while
// the output side is not stalling.
// Reset: synchronous, active low; all band levels and caps clear to zero and
// the sensitivity returns to 100 percent. There is no clearing pass.
// ----------------------------------------------------------------------------
//
// Structure
//   The front end registers each input beat and marks whether its band lies
//   within the state depth. A four-entry queue sits between the front end and
//   the back pipeline so that the input keeps flowing while a finished result
//   waits at the output.
//
//   The back pipeline has four stages that all advance together whenever the
//   output register is empty or being taken:
//     A  reads the band's smoothed level, moves it toward the magnitude and
//        writes it back in the same cycle, so a beat for the same band in the
//        next cycle already sees the update;
//     B  rounds the 8.8 level to an integer and multiplies it by the gain;
//     C  divides by 100 as a multiply by a reciprocal;
//     D  saturates at 255, updates the band's peak cap (read and written in
//        the same cycle) and loads the output register.
//   Because each piece of per-band state is read, updated and written within
//   one stage, no forwarding between stages is needed.
//
//   A beat whose band lies beyond the state depth leaves all state untouched
//   and returns a shown level and cap of zero.
//
//   The sensitivity register is expected to be written only while no beat is
//   in flight.
// ----------------------------------------------------------------------------
module band_meter_ballistics_peak_hold (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [7:0]                  i_cfg_wr_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [bmb_pkg::BAND_W-1:0]  i_band_index,
    input  logic [bmb_pkg::MAG_W-1:0]   i_band_magnitude,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [bmb_pkg::BAND_W-1:0]  o_out_band,
    output logic [bmb_pkg::LEVEL_W-1:0] o_shown_level,
    output logic [bmb_pkg::LEVEL_W-1:0] o_peak_cap
);
    import bmb_pkg::*;

    // Front end to queue.
    logic  push;
    t_item push_item;
    logic  q_full;

    // Queue to back pipeline.
    logic  pop;
    logic  q_valid;
    t_item q_item;

    bmb_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_band_index     (i_band_index),
        .i_band_magnitude (i_band_magnitude),
        .i_q_full         (q_full),
        .o_push           (push),
        .o_item           (push_item)
    );

    bmb_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (push_item),
        .o_full      (q_full),
        .i_pop       (pop),
        .o_valid     (q_valid),
        .o_item      (q_item)
    );

    bmb_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_valid     (q_valid),
        .i_q_item      (q_item),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_band    (o_out_band),
        .o_shown_level (o_shown_level),
        .o_peak_cap    (o_peak_cap)
    );

endmodule

[src/bmb_checker.sv]
// ----------------------------------------------------------------------------
// Band meter port checker
// Watches the top-level ports and flags behaviour that the band meter must
// never show.
// ----------------------------------------------------------------------------
module bmb_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [bmb_pkg::BAND_W-1:0]  o_out_band,
    input logic [bmb_pkg::LEVEL_W-1:0] o_shown_level,
    input logic [bmb_pkg::LEVEL_W-1:0] o_peak_cap
);
    import bmb_pkg::*;

    // A stalled result beat stays put with all of its fields.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_band)
            && $stable(o_shown_level) && $stable(o_peak_cap))
        else $error("result beat changed while stalled");

    // Reset empties the pipeline and the input side is free straight after.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not empty after reset");

    // A band beyond the state depth gives a zero level and cap.
    a_out_of_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (32'(o_out_band) >= NUM_BANDS)
            |-> (o_shown_level == '0) && (o_peak_cap == '0))
        else $error("out-of-range band gave a non-zero result");

    // With no beat arriving the input side cannot start to stall.
    a_stall_needs_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall && !i_in_valid |=> !o_in_stall)
        else $error("input stall raised without an accepted beat");

endmodule

bind band_meter_ballistics_peak_hold bmb_checker u_bmb_checker (.*);

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// Band meter ballistics and peak hold testbench
// A scripted driver pushes band beats and gain writes into the meter while a
// monitor predicts each band's smoothed level, shown level and peak cap, then
// checks every result beat in order. The idling rates of both sides are set
// in three pacing phases; in the last neither side idles.
// ----------------------------------------------------------------------------
module tb_top;
    import bmb_pkg::*;

    // Cycles without any accepted beat or gain write before the run is
    // abandoned. The slowest correct beat waits out a long sender gap, the
    // pipeline and a long receiver stall, far below this.
    localparam int WATCHDOG_LIMIT = 2000;
    // Cycles allowed after the last expected result before a gain write.
    localparam int SETTLE_CYCLES  = 8;
    // Cycles watched at the end for stray results.
    localparam int TAIL_CYCLES    = 16;
    localparam int SEGMENTS       = 15;
    localparam int SEGMENT_BEATS  = 48;

    // Kinds of step held in the driver's script.
    typedef enum logic [1:0] {
        STEP_BEAT,      // present one band beat
        STEP_GAIN,      // write the sensitivity register
        STEP_SETTLE,    // hold off until every expected result has come
        STEP_PACE       // change the idling rates of both sides
    } t_step_kind;

    typedef struct {
        t_step_kind        kind;
        logic [BAND_W-1:0] band;
        logic [MAG_W-1:0]  mag;
        logic [7:0]        gain;
        int                send_gap_pct;
        int                recv_stall_pct;
    } t_plan_step;

    typedef struct packed {
        logic [BAND_W-1:0]  band;
        logic [LEVEL_W-1:0] shown;
        logic [LEVEL_W-1:0] cap;
    } t_meter_reading;

    // Clock, reset and every block input start at known values.
    logic                 i_clk            = 1'b0;
    logic                 i_rst_n          = 1'b0;
    logic                 i_cfg_wr_en      = 1'b0;
    logic [7:0]           i_cfg_wr_data    = '0;
    logic                 i_in_valid       = 1'b0;
    logic [BAND_W-1:0]    i_band_index     = '0;
    logic [MAG_W-1:0]     i_band_magnitude = '0;
    logic                 i_out_stall      = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [BAND_W-1:0]    o_out_band;
    logic [LEVEL_W-1:0]   o_shown_level;
    logic [LEVEL_W-1:0]   o_peak_cap;

    // Predicted state of the meter: one 8.8 level and one cap per band,
    // plus the gain in percent.
    logic [SMOOTH_W-1:0]  band_level [NUM_BANDS];
    logic [LEVEL_W-1:0]   band_cap   [NUM_BANDS];
    logic [7:0]           gain_pct = SENS_RESET;

    t_plan_step           plan_q[$];
    t_meter_reading       reading_q[$];

    logic                 in_fire_q      = 1'b0;
    int                   send_gap_pct   = 0;
    int                   recv_stall_pct = 0;
    int                   settle_count   = 0;
    int                   quiet_cycles   = 0;
    int                   errors         = 0;
    int                   beats_in       = 0;
    int                   results_out    = 0;
    int                   gain_writes    = 0;

    band_meter_ballistics_peak_hold dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_band_index     (i_band_index),
        .i_band_magnitude (i_band_magnitude),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_band       (o_out_band),
        .o_shown_level    (o_shown_level),
        .o_peak_cap       (o_peak_cap)
    );

    always #1 i_clk = ~i_clk;

    // Moves one band's level towards the magnitude, scales it by the gain
    // and updates the peak cap. Returns the reading the meter should give.
    function automatic t_meter_reading advance_band(input logic [BAND_W-1:0] band,
                                                    input logic [MAG_W-1:0]  mag);
        t_meter_reading r;
        int unsigned    target;
        int unsigned    level;
        int unsigned    rounded;
        int unsigned    shown;
        int unsigned    cap;
        r.band  = band;
        r.shown = '0;
        r.cap   = '0;
        // A band beyond the state depth touches nothing and reads as zero.
        if (int'(band) < NUM_BANDS) begin
            target = {mag, 8'h00};
            level  = band_level[band];
            // Fast attack when rising, slow decay otherwise; the rounded
            // step never passes the target.
            if (target > level) begin
                level = level + (((target - level) * ATTACK_COEF + ROUND_HALF) >> 8);
            end else begin
                level = level - (((level - target) * DECAY_COEF + ROUND_HALF) >> 8);
            end
            band_level[band] = SMOOTH_W'(level);

            rounded = (level + ROUND_HALF) >> 8;
            if (rounded > LEVEL_MAX) rounded = LEVEL_MAX;
            shown = (rounded * gain_pct) / 100;
            if (shown > LEVEL_MAX) shown = LEVEL_MAX;

            // The cap only jumps on a strict rise; a tie counts as a fall.
            cap = band_cap[band];
            if (shown > cap) begin
                cap = shown;
            end else begin
                cap = (cap >= CAP_FALL) ? cap - CAP_FALL : 0;
            end
            band_cap[band] = LEVEL_W'(cap);

            r.shown = LEVEL_W'(shown);
            r.cap   = LEVEL_W'(cap);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    task automatic add_beat(input int band, input int mag);
        t_plan_step s;
        s.kind = STEP_BEAT;
        s.band = BAND_W'(band);
        s.mag  = MAG_W'(mag);
        plan_q.push_back(s);
    endtask

    // Every gain write waits for the meter to empty first, which also gives
    // the sender a full pause on each change.
    task automatic add_gain(input int pct);
        t_plan_step s;
        s.kind = STEP_SETTLE;
        plan_q.push_back(s);
        s.kind = STEP_GAIN;
        s.gain = 8'(pct);
        plan_q.push_back(s);
    endtask

    task automatic add_pace(input int gap, input int stall);
        t_plan_step s;
        s.kind           = STEP_PACE;
        s.send_gap_pct   = gap;
        s.recv_stall_pct = stall;
        plan_q.push_back(s);
    endtask

    // Driver: works through the script at the falling edge. A beat that has
    // not yet been taken is held unchanged; otherwise the next step is
    // started unless the sender chooses to idle this cycle.
    always @(negedge i_clk) begin
        t_plan_step head;
        logic       next_valid;
        logic       next_wr_en;
        if (i_rst_n) begin
            next_valid = i_in_valid && !in_fire_q;
            next_wr_en = 1'b0;
            if (!next_valid) begin
                while (plan_q.size() > 0 && plan_q[0].kind == STEP_PACE) begin
                    send_gap_pct   = plan_q[0].send_gap_pct;
                    recv_stall_pct = plan_q[0].recv_stall_pct;
                    void'(plan_q.pop_front());
                end
                if (plan_q.size() > 0) begin
                    head = plan_q[0];
                    case (head.kind)
                        STEP_BEAT: begin
                            if ($urandom_range(99) >= send_gap_pct) begin
                                next_valid = 1'b1;
                                i_band_index     <= head.band;
                                i_band_magnitude <= head.mag;
                                void'(plan_q.pop_front());
                            end
                        end
                        STEP_GAIN: begin
                            next_wr_en = 1'b1;
                            i_cfg_wr_data <= head.gain;
                            void'(plan_q.pop_front());
                        end
                        STEP_SETTLE: begin
                            if (reading_q.size() == 0) begin
                                if (settle_count >= SETTLE_CYCLES) begin
                                    settle_count = 0;
                                    void'(plan_q.pop_front());
                                end else begin
                                    settle_count++;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            i_in_valid  <= next_valid;
            i_cfg_wr_en <= next_wr_en;
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Monitor: at the rising edge, applies gain writes to the predictor,
    // predicts every accepted input beat and checks every accepted result
    // beat against the oldest prediction.
    always @(posedge i_clk) begin
        t_meter_reading want;
        logic           took_in;
        logic           took_out;
        took_in  = i_in_valid && !o_in_stall;
        took_out = o_out_valid && !i_out_stall;
        in_fire_q <= i_rst_n && took_in;
        if (i_rst_n) begin
            if (i_cfg_wr_en) begin
                gain_pct = i_cfg_wr_data;
                gain_writes++;
            end
            if (took_in) begin
                reading_q.push_back(advance_band(i_band_index, i_band_magnitude));
                beats_in++;
            end
            if (took_out) begin
                results_out++;
                if (reading_q.size() == 0) begin
                    report_mismatch("result with nothing pending, band", o_out_band, -1);
                end else begin
                    want = reading_q.pop_front();
                    if (o_out_band !== want.band)
                        report_mismatch("out_band", o_out_band, want.band);
                    if (o_shown_level !== want.shown)
                        report_mismatch("shown_level", o_shown_level, want.shown);
                    if (o_peak_cap !== want.cap)
                        report_mismatch("peak_cap", o_peak_cap, want.cap);
                end
            end
            quiet_cycles = (took_in || took_out || i_cfg_wr_en) ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat accepted for %0d cycles, %0d results pending",
                         WATCHDOG_LIMIT, reading_q.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Stimulus script, reset and end of run.
    initial begin
        int seg;
        int n;
        int g;
        int hot_band;
        int burst_mag;
        int style;

        for (int b = 0; b < NUM_BANDS; b++) begin
            band_level[b] = '0;
            band_cap[b]   = '0;
        end

        // Directed part. The sender idles lightly and the receiver heavily.
        add_pace(24, 66);
        add_gain(100);
        add_beat(3, 0);             // nothing rising: cap ties at zero and stays floored
        add_beat(0, 255);           // attack from silence
        add_beat(0, 255);
        add_beat(0, 255);
        add_beat(0, 0);             // decay, cap falls by three
        add_beat(0, 0);
        add_beat(0, 0);
        add_beat(31, 255);          // highest band
        add_beat(31, 0);
        add_beat(7, 8'hAA);
        add_beat(24, 8'h55);
        add_gain(0);                // zero gain shows nothing
        add_beat(0, 255);
        add_beat(9, 128);
        add_gain(255);              // full gain saturates the shown level
        add_beat(0, 255);
        add_beat(9, 200);
        add_beat(9, 1);
        add_gain(40);
        add_beat(31, 255);
        add_beat(16, 100);
        add_gain(250);
        add_beat(16, 255);
        add_beat(16, 0);

        // Random part in segments, each with its own gain and a favoured
        // band that is hit again and again so that attack and decay run
        // their whole course.
        for (seg = 0; seg < SEGMENTS; seg++) begin
            if (seg == SEGMENTS / 3)     add_pace(66, 24);
            if (seg == 2 * SEGMENTS / 3) add_pace(0, 0);
            case (seg % 4)
                0:       g = $urandom_range(250, 40);
                1:       g = (seg % 8 == 1) ? 40 : 250;
                2:       g = $urandom_range(255, 0);
                default: g = 100;
            endcase
            add_gain(g);
            hot_band  = $urandom_range(NUM_BANDS - 1);
            burst_mag = ($urandom_range(1) == 1) ? 255 : 0;
            for (n = 0; n < SEGMENT_BEATS; n++) begin
                if (n % 12 == 0) burst_mag = 255 - burst_mag;
                style = $urandom_range(3);
                case (style)
                    0:       add_beat($urandom_range(NUM_BANDS - 1), $urandom_range(255));
                    1:       add_beat(hot_band, $urandom_range(255));
                    2:       add_beat(hot_band, burst_mag);
                    default: add_beat($urandom_range(3), $urandom_range(255));
                endcase
            end
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (!(plan_q.size() == 0 && !i_in_valid && reading_q.size() == 0))
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d band beats and %0d results over %0d gain settings,",
                 beats_in, results_out, gain_writes);
        $display("under three idling phases; %0d mismatches", errors);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
